// ===== rtl/core/dmh_pkg.sv =====
// Shared types and defaults for the dictionary match highlighter.
package dmh_pkg;

  localparam int NumWordsDef   = 16;
  localparam int MaxWordLenDef = 16;

  // Input item kinds
  typedef enum logic [1:0] {
    FuncText     = 2'd0,
    FuncDictByte = 2'd1,
    FuncDictLen  = 2'd2
  } func_e;

  // One released text byte with its tag flags
  typedef struct packed {
    logic [7:0] out_char;
    logic       open_tag;
    logic       close_tag;
    logic       last_out;
  } beat_t;

  // Dictionary load request
  typedef struct packed {
    logic       byte_en;
    logic       len_en;
    logic [3:0] word;
    logic [3:0] pos;
    logic [7:0] data;
  } dict_wr_t;

endpackage

// ===== rtl/core/dmh_matcher.sv =====
// Dictionary storage and parallel word comparison against the text window.
module dmh_matcher import dmh_pkg::*; #(
  parameter int NumWords = NumWordsDef,
  parameter int MaxLen   = MaxWordLenDef,
  localparam int LenW    = $clog2(MaxLen + 1),
  localparam int IdxW    = (MaxLen > 1) ? $clog2(MaxLen) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dict_wr_t               wr_i,
  // window after the newest byte is shifted in, newest byte at index 0
  input  logic [MaxLen-1:0][7:0] win_i,
  input  logic [LenW-1:0]        count_i,
  output logic [MaxLen-1:0]      cover_o
);

  logic [7:0]      dict_q [NumWords][MaxLen];
  logic [LenW-1:0] len_q  [NumWords];
  logic [NumWords-1:0] hit;
  logic            byte_ok;
  logic            len_ok;
  logic [LenW-1:0] len_sat;

  // Qualify load requests and clamp the word length
  always_comb begin
    byte_ok = wr_i.byte_en && (int'(wr_i.word) < NumWords) && (int'(wr_i.pos) < MaxLen);
    len_ok  = wr_i.len_en && (int'(wr_i.word) < NumWords);
    len_sat = (int'(wr_i.data) > MaxLen) ? LenW'(MaxLen) : wr_i.data[LenW-1:0];
  end

  // Store dictionary bytes, one cell per word and position
  always_ff @(posedge clk_i) begin
    for (int w = 0; w < NumWords; w++) begin
      for (int k = 0; k < MaxLen; k++) begin
        if (byte_ok && (int'(wr_i.word) == w) && (int'(wr_i.pos) == k)) begin
          dict_q[w][k] <= wr_i.data;
        end
      end
    end
  end

  // Store word lengths; zero marks an unused entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NumWords; w++) begin
        len_q[w] <= '0;
      end
    end else begin
      for (int w = 0; w < NumWords; w++) begin
        if (len_ok && (int'(wr_i.word) == w)) begin
          len_q[w] <= len_sat;
        end
      end
    end
  end

  // Compare every word ending at the newest byte
  always_comb begin
    logic [LenW-1:0] pos;
    pos = '0;
    for (int w = 0; w < NumWords; w++) begin
      hit[w] = (len_q[w] != '0) && (len_q[w] <= count_i);
      for (int k = 0; k < MaxLen; k++) begin
        pos = len_q[w] - LenW'(k) - LenW'(1);
        if (LenW'(k) < len_q[w]) begin
          if (dict_q[w][k] != win_i[pos[IdxW-1:0]]) begin
            hit[w] = 1'b0;
          end
        end
      end
    end
  end

  // Mark the newest positions covered by each hit
  always_comb begin
    for (int j = 0; j < MaxLen; j++) begin
      cover_o[j] = 1'b0;
      for (int w = 0; w < NumWords; w++) begin
        if (hit[w] && (LenW'(j) < len_q[w])) begin
          cover_o[j] = 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/dmh_skid.sv =====
// Two-entry output buffer: output register plus skid register.
module dmh_skid import dmh_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  input  beat_t push_beat_i,
  output logic  push_ready_o,
  output logic  out_valid_o,
  output beat_t out_beat_o,
  input  logic  out_stall_i
);

  logic  main_valid_q;
  logic  skid_valid_q;
  beat_t main_q;
  beat_t skid_q;
  logic  pop;

  assign pop          = main_valid_q && !out_stall_i;
  assign push_ready_o = !skid_valid_q;
  assign out_valid_o  = main_valid_q;
  assign out_beat_o   = main_q;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_valid_i) begin
      if (main_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  // Move beats; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_valid_i) begin
      if (main_valid_q && !pop) begin
        skid_q <= push_beat_i;
      end else begin
        main_q <= push_beat_i;
      end
    end
  end

endmodule

// ===== rtl/core/dictionary_match_highlighter.sv =====
// Dictionary match highlighter top level: text window, release control, output buffer.
// Throughput: one item per cycle while in_stall_o is low; released bytes are registered.
// End of text: held bytes are pushed one per cycle while the output buffer has room, from
//   the cycle after accept; input stalls until all of them are pushed.
// Reset clears the fill count, cover bits, word lengths and output buffer valid flags;
//   dictionary and window bytes are undefined until written.
module dictionary_match_highlighter import dmh_pkg::*; #(
  parameter int NumWords   = NumWordsDef,
  parameter int MaxWordLen = MaxWordLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [3:0] word_index_i,
  input  logic [3:0] char_pos_i,
  input  logic [7:0] value_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       open_tag_o,
  output logic       close_tag_o,
  output logic       last_out_o
);

  localparam int CntW = $clog2(MaxWordLen + 1);
  localparam int IdxW = (MaxWordLen > 1) ? $clog2(MaxWordLen) : 1;

  typedef enum logic {
    StRun,
    StFlush
  } state_e;

  state_e                     state_q, state_d;
  logic [CntW-1:0]            fill_q, fill_d;
  logic                       prev_bold_q, prev_bold_d;
  logic [IdxW-1:0]            flush_idx_q, flush_idx_d;
  logic [MaxWordLen-1:0]      cov_q, cov_d;
  logic [MaxWordLen-1:0][7:0] win_q;

  logic                       in_acc;
  logic                       text_acc;
  dict_wr_t                   dict_wr;
  logic [MaxWordLen-1:0][7:0] shift_win;
  logic [MaxWordLen-1:0]      cov_sh;
  logic [MaxWordLen-1:0]      match_cover;
  logic [MaxWordLen-1:0]      cov_new;
  logic [MaxWordLen-1:0]      cov_new_sh;
  logic [CntW-1:0]            n_new;
  logic                       rel;
  logic                       push_valid;
  logic                       push_ready;
  beat_t                      push_beat;
  beat_t                      out_beat;

  // Accept and decode the input beat
  always_comb begin
    in_stall_o      = (state_q == StFlush) || !push_ready;
    in_acc          = in_valid_i && !in_stall_o;
    text_acc        = in_acc && (func_e'(func_i) == FuncText);
    dict_wr.byte_en = in_acc && (func_e'(func_i) == FuncDictByte);
    dict_wr.len_en  = in_acc && (func_e'(func_i) == FuncDictLen);
    dict_wr.word    = word_index_i;
    dict_wr.pos     = char_pos_i;
    dict_wr.data    = value_i;
  end

  // Shift the new byte into the window, newest at index 0
  always_comb begin
    shift_win[0] = value_i;
    for (int j = 1; j < MaxWordLen; j++) begin
      shift_win[j] = win_q[j-1];
    end
    cov_sh     = cov_q << 1;
    n_new      = fill_q + CntW'(1);
    cov_new    = cov_sh | match_cover;
    cov_new_sh = cov_new << 1;
    rel        = text_acc && !end_of_text_i && (n_new == CntW'(MaxWordLen));
  end

  dmh_matcher #(
    .NumWords (NumWords),
    .MaxLen   (MaxWordLen)
  ) u_matcher (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (dict_wr),
    .win_i   (shift_win),
    .count_i (n_new),
    .cover_o (match_cover)
  );

  // Release one byte when the window fills, or drain it at end of text
  always_comb begin
    logic bold;
    logic close;
    bold        = 1'b0;
    close       = 1'b0;
    state_d     = state_q;
    fill_d      = fill_q;
    prev_bold_d = prev_bold_q;
    flush_idx_d = flush_idx_q;
    cov_d       = cov_q;
    push_valid  = 1'b0;
    push_beat   = '0;
    unique case (state_q)
      StRun: begin
        if (text_acc) begin
          cov_d = cov_new;
          if (end_of_text_i) begin
            state_d     = StFlush;
            flush_idx_d = fill_q[IdxW-1:0];
          end else if (rel) begin
            bold                = cov_new[MaxWordLen-1];
            close               = bold && !cov_new_sh[MaxWordLen-1];
            push_valid          = 1'b1;
            push_beat.out_char  = shift_win[MaxWordLen-1];
            push_beat.open_tag  = bold && !prev_bold_q;
            push_beat.close_tag = close;
            push_beat.last_out  = 1'b0;
            prev_bold_d         = bold && !close;
            fill_d              = CntW'(MaxWordLen - 1);
          end else begin
            fill_d = n_new;
          end
        end
      end
      StFlush: begin
        if (push_ready) begin
          bold                = cov_q[flush_idx_q];
          close               = bold && !cov_sh[flush_idx_q];
          push_valid          = 1'b1;
          push_beat.out_char  = win_q[flush_idx_q];
          push_beat.open_tag  = bold && !prev_bold_q;
          push_beat.close_tag = close;
          push_beat.last_out  = (flush_idx_q == '0);
          prev_bold_d         = bold && !close;
          if (flush_idx_q == '0) begin
            state_d     = StRun;
            fill_d      = '0;
            prev_bold_d = 1'b0;
            cov_d       = '0;
          end else begin
            flush_idx_d = flush_idx_q - IdxW'(1);
          end
        end
      end
      default: begin
        state_d = StRun;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      fill_q      <= '0;
      prev_bold_q <= 1'b0;
      flush_idx_q <= '0;
      cov_q       <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      prev_bold_q <= prev_bold_d;
      flush_idx_q <= flush_idx_d;
      cov_q       <= cov_d;
    end
  end

  // Hold window bytes
  always_ff @(posedge clk_i) begin
    if (text_acc) begin
      win_q <= shift_win;
    end
  end

  dmh_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_beat_i  (push_beat),
    .push_ready_o (push_ready),
    .out_valid_o  (out_valid_o),
    .out_beat_o   (out_beat),
    .out_stall_i  (out_stall_i)
  );

  assign out_char_o  = out_beat.out_char;
  assign open_tag_o  = out_beat.open_tag;
  assign close_tag_o = out_beat.close_tag;
  assign last_out_o  = out_beat.last_out;

endmodule

// ===== rtl/core/dmh_checker.sv =====
// Port-level checks on the highlighter output stream, bound to the top level.
module dmh_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_char_o,
  input logic       open_tag_o,
  input logic       close_tag_o,
  input logic       last_out_o
);

  logic run_open_q;
  logic out_acc;

  assign out_acc = out_valid_o && !out_stall_i;

  // Track whether a bold run is open across accepted beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q <= 1'b0;
    end else if (out_acc) begin
      run_open_q <= !last_out_o && (open_tag_o || run_open_q) && !close_tag_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_char_o) && $stable(open_tag_o) &&
      $stable(close_tag_o) && $stable(last_out_o))
    else $error("output beat changed while stalled");

  a_no_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_open_q |-> !open_tag_o)
    else $error("open tag inside an open run");

  a_lone_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_open_q && close_tag_o |-> open_tag_o)
    else $error("close tag without an open run");

endmodule

bind dictionary_match_highlighter dmh_checker u_dmh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_char_o  (out_char_o),
  .open_tag_o  (open_tag_o),
  .close_tag_o (close_tag_o),
  .last_out_o  (last_out_o)
);

// ===== tb/sv/dictionary_match_highlighter_test.sv =====
// Self-checking testbench for the dictionary match highlighter with a built-in predictor.
module dictionary_match_highlighter_test;
  import dmh_pkg::*;

  localparam int         NumWords   = NumWordsDef;
  localparam int         MaxLen     = MaxWordLenDef;
  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int         ItemGoal   = 170;
  localparam int         CalmAfter  = 140;
  localparam int         IdleLimit  = 1000;
  localparam int         HoldCycles = 100;
  localparam int         FillText   = 64;

  // Predicts released text beats and checks them in order
  class highlight_scoreboard;
    logic [7:0]  dict_mem [NumWords][MaxLen];
    int unsigned word_len [NumWords];
    logic [7:0]  win_char [MaxLen];
    bit          win_cover [MaxLen];
    int unsigned held;
    bit          run_open;
    beat_t       pending_beats [$];
    int          errors;

    function new();
      foreach (word_len[w]) word_len[w] = 0;
      foreach (win_char[k]) begin
        win_char[k]  = '0;
        win_cover[k] = 1'b0;
      end
      held     = 0;
      run_open = 1'b0;
      errors   = 0;
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction

    // Mark every window position covered by a word ending at the newest byte
    function void mark_hits(int unsigned n);
      int unsigned l;
      bit          hit;
      for (int unsigned w = 0; w < NumWords; w++) begin
        l = word_len[w];
        if (l == 0 || l > n) continue;
        hit = 1'b1;
        for (int unsigned k = 0; k < l; k++) begin
          if (dict_mem[w][k] != win_char[n - l + k]) hit = 1'b0;
        end
        if (hit) begin
          for (int unsigned k = n - l; k < n; k++) win_cover[k] = 1'b1;
        end
      end
    endfunction

    // Queue one released byte with its tag flags
    function void release_char(int unsigned pos, bit shut, bit last);
      beat_t b;
      b.out_char  = win_char[pos];
      b.open_tag  = win_cover[pos] && !run_open;
      b.close_tag = shut;
      b.last_out  = last;
      run_open    = win_cover[pos] && !shut;
      pending_beats = {pending_beats, b};
    endfunction

    function void note_item(logic [1:0] fn, logic [3:0] wi, logic [3:0] cp, logic [7:0] val,
                            logic eot);
      int unsigned n;
      bit          shut;
      bit          last;
      case (fn)
        FuncDictByte: begin
          dict_mem[wi][cp] = val;
        end
        FuncDictLen: begin
          word_len[wi] = (val > MaxLen) ? MaxLen : val;
        end
        FuncText: begin
          n = held;
          win_char[n]  = val;
          win_cover[n] = 1'b0;
          n++;
          mark_hits(n);
          if (eot) begin
            // Flush the whole window, then clear it
            for (int unsigned k = 0; k < n; k++) begin
              last = (k + 1 == n);
              shut = win_cover[k] && (last || !win_cover[k + 1]);
              release_char(k, shut, last);
            end
            foreach (win_char[k]) begin
              win_char[k]  = '0;
              win_cover[k] = 1'b0;
            end
            held     = 0;
            run_open = 1'b0;
          end else if (n == MaxLen) begin
            // Release the oldest byte and advance the window
            shut = win_cover[0] && !win_cover[1];
            release_char(0, shut, 1'b0);
            for (int unsigned k = 1; k < n; k++) begin
              win_char[k - 1]  = win_char[k];
              win_cover[k - 1] = win_cover[k];
            end
            win_char[n - 1]  = '0;
            win_cover[n - 1] = 1'b0;
            held = n - 1;
          end else begin
            held = n;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_beat(beat_t got);
      beat_t want;
      if (pending_beats.size() == 0) begin
        report($sformatf("beat %h with nothing expected", got.out_char));
        return;
      end
      want = pending_beats.pop_front();
      if (got.out_char !== want.out_char)
        report($sformatf("out_char %h, want %h", got.out_char, want.out_char));
      if (got.open_tag !== want.open_tag)
        report($sformatf("open_tag %b, want %b (char %h)", got.open_tag, want.open_tag,
                         want.out_char));
      if (got.close_tag !== want.close_tag)
        report($sformatf("close_tag %b, want %b (char %h)", got.close_tag, want.close_tag,
                         want.out_char));
      if (got.last_out !== want.last_out)
        report($sformatf("last_out %b, want %b (char %h)", got.last_out, want.last_out,
                         want.out_char));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] func_i;
  logic [3:0] word_index_i;
  logic [3:0] char_pos_i;
  logic [7:0] value_i;
  logic       end_of_text_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_char_o;
  logic       open_tag_o;
  logic       close_tag_o;
  logic       last_out_o;

  highlight_scoreboard sb;
  logic [15:0]         byte_seen [NumWords];
  int                  items_sent  = 0;
  int                  idle_cycles = 0;
  int                  gap_pct     = 20;
  int                  stall_pct   = 20;
  bit                  calm        = 1'b0;
  bit                  hold_req    = 1'b0;

  dictionary_match_highlighter u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Pick a text or word byte, mostly from a small alphabet so words hit often
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 99) < 85) return 8'("a" + $urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 3);
    if (r < 70) return $urandom_range(4, 8);
    if (r < 80) return 0;
    if (r < 90) return MaxLen;
    return $urandom_range(MaxLen + 1, 255);
  endfunction

  // Offer one beat at the falling edge and hold it until accepted
  task automatic push_item(logic [1:0] fn, logic [3:0] wi, logic [3:0] cp, logic [7:0] val,
                           logic eot);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    func_i        = fn;
    word_index_i  = wi;
    char_pos_i    = cp;
    value_i       = val;
    end_of_text_i = eot;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(fn, wi, cp, val, eot);
    if (fn != FuncUnused) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic load_byte(int w, int p, logic [7:0] v);
    push_item(FuncDictByte, 4'(w), 4'(p), v, 1'($urandom));
    byte_seen[w][p] = 1'b1;
  endtask

  // Write a word length; first write each byte it covers that was never loaded, others at random
  task automatic load_len(int w, int v, bit same_char);
    int fill;
    fill = (v > MaxLen) ? MaxLen : v;
    for (int k = 0; k < fill; k++) begin
      if (same_char || !byte_seen[w][k] || $urandom_range(0, 1))
        load_byte(w, k, same_char ? 8'("a") : pick_char());
    end
    push_item(FuncDictLen, 4'(w), 4'($urandom), 8'(v), 1'($urandom));
  endtask

  task automatic send_chars(string s, bit eot_last);
    for (int i = 0; i < s.len(); i++)
      push_item(FuncText, 4'($urandom), 4'($urandom), s[i], eot_last && i == s.len() - 1);
  endtask

  // Stream a text with stray ignored beats and dictionary byte writes mixed in
  task automatic send_text(int len, bit run_of_a);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 4)
        push_item(FuncUnused, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
      else if ($urandom_range(0, 99) < 3)
        load_byte($urandom_range(0, NumWords - 1), $urandom_range(0, MaxLen - 1),
                  pick_char());
      push_item(FuncText, 4'($urandom), 4'($urandom), run_of_a ? 8'("a") : pick_char(),
                i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Output side: random stall bursts, one long hold on request, check every beat
  initial begin
    int    idle_left;
    int    hold_left;
    beat_t got;
    idle_left   = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (idle_left > 0) begin
        out_stall_i = 1'b1;
        idle_left--;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i = 1'b1;
        idle_left   = $urandom_range(0, 4);
      end else begin
        out_stall_i = 1'b0;
      end
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.out_char  = out_char_o;
        got.open_tag  = open_tag_o;
        got.close_tag = close_tag_o;
        got.last_out  = last_out_o;
        sb.check_beat(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
    end
  end

  // Stop the run when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int texts;
    int n_len;
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = FuncText;
    word_index_i  = '0;
    char_pos_i    = '0;
    value_i       = '0;
    end_of_text_i = 1'b0;
    foreach (byte_seen[w]) byte_seen[w] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: overlapping and adjacent words, a zero byte, an unused entry,
    // a saturated full-length word, and an ignored function code
    load_byte(0, 0, "a");
    load_byte(0, 1, "b");
    load_len(0, 2, 1'b0);
    load_byte(1, 0, "b");
    load_byte(1, 1, "c");
    load_len(1, 2, 1'b0);
    load_byte(2, 0, 8'h00);
    load_len(2, 1, 1'b0);
    load_byte(3, 0, "z");
    load_len(3, 0, 1'b0);
    for (int k = 0; k < MaxLen; k++) load_byte(15, k, 8'hFF);
    push_item(FuncDictLen, 4'd15, 4'hF, 8'hFF, 1'b1);
    push_item(FuncUnused, 4'hF, 4'hF, 8'hFF, 1'b1);
    send_chars("abcab", 1'b0);
    push_item(FuncText, 4'hF, 4'hF, 8'h00, 1'b1);
    // short text: a two-byte word cannot match one byte
    send_chars("a", 1'b1);
    // a run closes just before a full-length match starts
    send_chars("ab", 1'b0);
    for (int k = 0; k < MaxLen; k++)
      push_item(FuncText, 4'h0, 4'h0, 8'hFF, k == MaxLen - 1);
    wait_drained();

    // Random: seed a few short words, then stream texts of mixed length
    for (int w = 4; w < 10; w++) load_len(w, $urandom_range(1, 3), 1'b0);
    texts = 0;
    while (items_sent < ItemGoal) begin
      if (items_sent >= CalmAfter) calm = 1'b1;
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 30;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 30;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        n_len = pick_len();
        load_len($urandom_range(0, NumWords - 1), n_len,
                 n_len >= MaxLen && $urandom_range(0, 1));
      end
      if (texts == 3) begin
        // hold the output off while a long text keeps coming, so the input stalls
        gap_pct  = 0;
        hold_req = 1'b1;
        send_text(FillText, 1'b0);
      end else if ($urandom_range(0, 9) == 0) begin
        send_text($urandom_range(14, 20), 1'b1);
      end else if ($urandom_range(0, 3) == 0) begin
        send_text($urandom_range(13, 30), 1'b0);
      end else begin
        send_text($urandom_range(1, 12), 1'b0);
      end
      if ($urandom_range(0, 4) == 0) wait_drained();
      texts++;
    end

    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dmh_pkg.sv
rtl/core/dmh_matcher.sv
rtl/core/dmh_skid.sv
rtl/core/dictionary_match_highlighter.sv
rtl/core/dmh_checker.sv
tb/sv/dictionary_match_highlighter_test.sv
